/* hw/rtl/quaternion_between_vectors_core_defines.svh */
// assertion macros for the quaternion core
// expects a clock named clk and a reset named rst in the including module
`ifndef QUATERNION_BETWEEN_VECTORS_CORE_DEFINES_SVH
`define QUATERNION_BETWEEN_VECTORS_CORE_DEFINES_SVH

// condition must hold in the same cycle
`define QBV_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition must hold in the following cycle
`define QBV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/qbv_pkg.sv */
// shared constants and types of the quaternion core
// no dependencies
package qbv_pkg;

  localparam int COMP_BITS = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_BITS  = 16;
  localparam int WORK_FRAC = 30;

  // signed unit component, Q1.30 magnitude up to 2^30
  localparam int UW = WORK_FRAC + 2;
  // signed Q.30 intermediate results
  localparam int QW = WORK_FRAC + 4;

  localparam int RAD_BITS  = 64;
  localparam int ROOT_BITS = RAD_BITS / 2;

  localparam int ISQRT_LAT = ROOT_BITS;
  localparam int DIV_LAT   = ROOT_BITS;
  localparam int NORM_LAT  = 4 + ISQRT_LAT + 1 + DIV_LAT + 1;
  localparam int PROD_LAT  = 4;
  localparam int REG_LAT   = ISQRT_LAT + 1 + DIV_LAT + 1;
  localparam int REG_DLY   = NORM_LAT - REG_LAT;
  localparam int PIPE_LAT  = NORM_LAT + PROD_LAT + NORM_LAT + 1;

  // -1.0 + 0.001 in Q.30
  localparam logic signed [QW-1:0] OPP_LIMIT = -34'sd1072668082;
  // 0.01 in Q.60
  localparam logic [63:0] SMALL_AXIS_SQ = 64'd11529215046068470;

  typedef struct packed {
    logic signed [UW-1:0] x;
    logic signed [UW-1:0] y;
    logic signed [UW-1:0] z;
  } vec3_t;

  typedef struct packed {
    vec3_t u;
    logic  ok;
  } unit_t;

endpackage

/* hw/rtl/quaternion_between_vectors_core.sv */
// top level of the quaternion-between-vectors core
// depends on qbv_pkg, qbv_norm, qbv_isqrt, qbv_div and the assertion macro header
//
// Takes one pair of 3D vectors (signed 16-bit components, only direction
// matters) per transaction and returns the unit quaternion that turns the
// start vector onto the destination, in Q2.14 (16384 is 1.0). The core is a
// single pipeline that accepts a transaction every cycle while not held and
// returns the results in the order taken. The depth comes from two passes of
// the vector normalizer (70 stages each: a 32-stage square root and a
// 32-stage divider, one result bit per stage) plus four product stages and
// the output register; the half-angle path (square root and three dividers)
// runs beside the second normalizer. While a finished result waits under
// result_stall the whole pipeline holds and item_stall rises; nothing is
// dropped or repeated. Nearly opposite vectors return a half turn about a
// fallback axis and raise opposite_case; a zero vector on either side
// raises degenerate and returns zeros.
`include "quaternion_between_vectors_core_defines.svh"

module quaternion_between_vectors_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic signed [qbv_pkg::COMP_BITS-1:0] start_x,
  input  logic signed [qbv_pkg::COMP_BITS-1:0] start_y,
  input  logic signed [qbv_pkg::COMP_BITS-1:0] start_z,
  input  logic signed [qbv_pkg::COMP_BITS-1:0] dest_x,
  input  logic signed [qbv_pkg::COMP_BITS-1:0] dest_y,
  input  logic signed [qbv_pkg::COMP_BITS-1:0] dest_z,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [qbv_pkg::OUT_BITS-1:0]  quat_w,
  output logic signed [qbv_pkg::OUT_BITS-1:0]  quat_x,
  output logic signed [qbv_pkg::OUT_BITS-1:0]  quat_y,
  output logic signed [qbv_pkg::OUT_BITS-1:0]  quat_z,
  output logic                                 opposite_case,
  output logic                                 degenerate
);
  import qbv_pkg::*;

  // output scaling
  localparam int OSH     = WORK_FRAC - FRAC_BITS;
  localparam int HALF    = (1 << OSH) >> 1;
  localparam int ONE     = 1 << FRAC_BITS;
  localparam int HI      = (1 << (OUT_BITS - 1)) - 1;
  localparam int POS_LIM = (ONE < HI) ? ONE : HI;
  localparam int NEG_LIM = (ONE < HI + 1) ? ONE : HI + 1;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } cr3_t;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic [2:0]           neg;
  } rside_t;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } q4_t;

  // sign-magnitude rounding shift of a Q.60 product sum down to Q.30
  function automatic logic signed [QW-1:0] round30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] rnd;
    mag = v[63] ? 64'(-v) : 64'(v);
    rnd = (mag + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
    return v[63] ? -$signed(QW'(rnd)) : $signed(QW'(rnd));
  endfunction

  // Q.30 to output format: round, then clamp to one and to the field range
  function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [QW-1:0] q);
    logic [QW-1:0] mag;
    logic [QW-1:0] rnd;
    mag = q[QW-1] ? QW'(-q) : QW'(q);
    rnd = (mag + QW'(HALF)) >> OSH;
    if (q[QW-1]) begin
      if (rnd > QW'(NEG_LIM)) rnd = QW'(NEG_LIM);
      return -$signed(OUT_BITS'(rnd));
    end else begin
      if (rnd > QW'(POS_LIM)) rnd = QW'(POS_LIM);
      return $signed(OUT_BITS'(rnd));
    end
  endfunction

  logic                en;
  logic [PIPE_LAT-1:0] vld;

  // unit vectors
  vec3_t vec_a, vec_b;
  unit_t unit_a, unit_b;

  // product stages
  logic signed [63:0] pxx, pxy, pxz, pyx, pyy, pyz, pzx, pzy, pzz, sqx, sqy;
  vec3_t              ua1, ua2, ua3;
  logic               degen1, degen2, degen3, degen4;
  logic signed [63:0] dot2, crx2, cry2, crz2, lsq2;
  logic signed [QW-1:0] c30_3;
  cr3_t               cr3, cr4;
  logic               small3;
  logic signed [63:0] tt;
  logic               opp_now;
  logic [RAD_BITS-1:0] rad4;
  vec3_t              axis4;
  logic               opp4;

  // half-angle path
  logic [ROOT_BITS-1:0]      s_root;
  cr3_t                      line_r1 [ISQRT_LAT];
  cr3_t                      crr;
  logic [2:0][QW-1:0]        crm;
  logic [2:0][RAD_BITS-1:0]  num_r;
  logic [ROOT_BITS-1:0]      den_r;
  rside_t                    side_r;
  rside_t                    line_r2 [DIV_LAT];
  logic [2:0][ROOT_BITS-1:0] quo_r;
  q4_t                       q_reg;
  q4_t                       line_r3 [REG_DLY];

  // fallback axis path and flags
  unit_t      unit_ax;
  logic [1:0] line_f [NORM_LAT];
  logic       opp_f, degen_f;
  q4_t        fin;

  // pipeline advances unless a finished result is held by the consumer
  assign en           = !(vld[PIPE_LAT-1] && result_stall);
  assign item_stall   = !en;
  assign result_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], item_valid};
    end
  end

  assign vec_a.x = UW'(start_x);
  assign vec_a.y = UW'(start_y);
  assign vec_a.z = UW'(start_z);
  assign vec_b.x = UW'(dest_x);
  assign vec_b.y = UW'(dest_y);
  assign vec_b.z = UW'(dest_z);

  qbv_norm u_norm_a (
    .clk  (clk),
    .en   (en),
    .vec  (vec_a),
    .unit (unit_a)
  );

  qbv_norm u_norm_b (
    .clk  (clk),
    .en   (en),
    .vec  (vec_b),
    .unit (unit_b)
  );

  // dot product, cross product and the axis selection
  always_comb begin
    opp_now = !degen3 && (c30_3 < OPP_LIMIT);
    tt      = 64'(c30_3) + (64'sd1 <<< WORK_FRAC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: all pairwise products, plus the x and y squares of the start vector
      pxx <= unit_a.u.x * unit_b.u.x;
      pxy <= unit_a.u.x * unit_b.u.y;
      pxz <= unit_a.u.x * unit_b.u.z;
      pyx <= unit_a.u.y * unit_b.u.x;
      pyy <= unit_a.u.y * unit_b.u.y;
      pyz <= unit_a.u.y * unit_b.u.z;
      pzx <= unit_a.u.z * unit_b.u.x;
      pzy <= unit_a.u.z * unit_b.u.y;
      pzz <= unit_a.u.z * unit_b.u.z;
      sqx <= unit_a.u.x * unit_a.u.x;
      sqy <= unit_a.u.y * unit_a.u.y;
      ua1    <= unit_a.u;
      degen1 <= !(unit_a.ok && unit_b.ok);
      // stage 2: sums and differences
      dot2   <= pxx + pyy + pzz;
      crx2   <= pyz - pzy;
      cry2   <= pzx - pxz;
      crz2   <= pxy - pyx;
      lsq2   <= sqx + sqy;
      ua2    <= ua1;
      degen2 <= degen1;
      // stage 3: back to Q.30
      c30_3  <= round30(dot2);
      cr3.x  <= round30(crx2);
      cr3.y  <= round30(cry2);
      cr3.z  <= round30(crz2);
      small3 <= (64'(lsq2) < SMALL_AXIS_SQ);
      ua3    <= ua2;
      degen3 <= degen2;
      // stage 4: opposite test, half-angle radicand, fallback axis
      opp4   <= opp_now;
      degen4 <= degen3;
      cr4    <= cr3;
      rad4   <= opp_now ? '0 : RAD_BITS'(tt << (WORK_FRAC + 1));
      if (small3) begin
        axis4.x <= '0;
        axis4.y <= -ua3.z;
        axis4.z <= ua3.y;
      end else begin
        axis4.x <= -ua3.y;
        axis4.y <= ua3.x;
        axis4.z <= '0;
      end
    end
  end

  // half-angle path: s = sqrt(2(1+c)), w = s/2, xyz = cross/s
  qbv_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad4),
    .root (s_root)
  );

  always_comb begin
    crr    = line_r1[ISQRT_LAT-1];
    crm[0] = crr.x[QW-1] ? QW'(-crr.x) : QW'(crr.x);
    crm[1] = crr.y[QW-1] ? QW'(-crr.y) : QW'(crr.y);
    crm[2] = crr.z[QW-1] ? QW'(-crr.z) : QW'(crr.z);
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    qbv_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[i]),
      .den (den_r),
      .quo (quo_r[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_r1[0] <= cr4;
      for (int k = 1; k < ISQRT_LAT; k++) line_r1[k] <= line_r1[k-1];
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (RAD_BITS'(crm[i]) << WORK_FRAC) + RAD_BITS'(s_root >> 1);
      end
      den_r      <= s_root;
      side_r.w   <= $signed((QW'(s_root) + QW'(1)) >> 1);
      side_r.neg <= {crr.z[QW-1], crr.y[QW-1], crr.x[QW-1]};
      line_r2[0] <= side_r;
      for (int k = 1; k < DIV_LAT; k++) line_r2[k] <= line_r2[k-1];
      q_reg.w <= line_r2[DIV_LAT-1].w;
      q_reg.x <= line_r2[DIV_LAT-1].neg[0] ? -$signed(QW'(quo_r[0]))
                                           : $signed(QW'(quo_r[0]));
      q_reg.y <= line_r2[DIV_LAT-1].neg[1] ? -$signed(QW'(quo_r[1]))
                                           : $signed(QW'(quo_r[1]));
      q_reg.z <= line_r2[DIV_LAT-1].neg[2] ? -$signed(QW'(quo_r[2]))
                                           : $signed(QW'(quo_r[2]));
      // line up with the fallback axis normalizer
      line_r3[0] <= q_reg;
      for (int k = 1; k < REG_DLY; k++) line_r3[k] <= line_r3[k-1];
    end
  end

  // fallback axis normalizer for nearly opposite vectors
  qbv_norm u_norm_ax (
    .clk  (clk),
    .en   (en),
    .vec  (axis4),
    .unit (unit_ax)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      line_f[0] <= {opp4, degen4};
      for (int k = 1; k < NORM_LAT; k++) line_f[k] <= line_f[k-1];
    end
  end

  // result selection and output register
  always_comb begin
    opp_f   = line_f[NORM_LAT-1][1];
    degen_f = line_f[NORM_LAT-1][0];
    fin     = line_r3[REG_DLY-1];
    if (opp_f) begin
      fin.w = '0;
      fin.x = QW'(unit_ax.u.x);
      fin.y = QW'(unit_ax.u.y);
      fin.z = QW'(unit_ax.u.z);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_w        <= degen_f ? '0 : to_out(fin.w);
      quat_x        <= degen_f ? '0 : to_out(fin.x);
      quat_y        <= degen_f ? '0 : to_out(fin.y);
      quat_z        <= degen_f ? '0 : to_out(fin.z);
      opposite_case <= opp_f;
      degenerate    <= degen_f;
    end
  end

  // zero-vector results carry no rotation and no fallback flag
  `QBV_ASSERT_NOW(a_degen_zero, result_valid && degenerate, quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0 && !opposite_case, "degenerate result with nonzero quaternion")
  // a half turn has no scalar part
  `QBV_ASSERT_NOW(a_opp_w, result_valid && opposite_case, quat_w == '0 && !degenerate, "half turn with nonzero w")
  // a held pipeline keeps every valid bit in place
  `QBV_ASSERT_NEXT(a_hold, !en, $stable(vld), "pipeline moved while held")

endmodule

/* hw/rtl/qbv_isqrt.sv */
// pipelined floor integer square root, one root bit per stage
// depends on qbv_pkg
module qbv_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [qbv_pkg::RAD_BITS-1:0]   rad,
  output logic [qbv_pkg::ROOT_BITS-1:0]  root
);
  import qbv_pkg::*;

  localparam int RW = ROOT_BITS + 4;

  logic [RAD_BITS-1:0]  rad_in    [ISQRT_LAT];
  logic [RW-1:0]        rem_in    [ISQRT_LAT];
  logic [ROOT_BITS-1:0] root_in   [ISQRT_LAT];
  logic [RAD_BITS-1:0]  rad_next  [ISQRT_LAT];
  logic [RW-1:0]        rem_next  [ISQRT_LAT];
  logic [ROOT_BITS-1:0] root_next [ISQRT_LAT];
  logic [RW-1:0]        rem_sh    [ISQRT_LAT];
  logic [RW-1:0]        trial     [ISQRT_LAT];
  logic [RAD_BITS-1:0]  rad_q     [ISQRT_LAT];
  logic [RW-1:0]        rem_q     [ISQRT_LAT];
  logic [ROOT_BITS-1:0] root_q    [ISQRT_LAT];

  always_comb begin
    rad_in[0]  = rad;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int j = 1; j < ISQRT_LAT; j++) begin
      rad_in[j]  = rad_q[j-1];
      rem_in[j]  = rem_q[j-1];
      root_in[j] = root_q[j-1];
    end
    for (int j = 0; j < ISQRT_LAT; j++) begin
      rem_sh[j]   = {rem_in[j][RW-3:0], rad_in[j][RAD_BITS-1 -: 2]};
      trial[j]    = RW'({root_in[j], 2'b01});
      rad_next[j] = rad_in[j] << 2;
      if (rem_sh[j] >= trial[j]) begin
        rem_next[j]  = rem_sh[j] - trial[j];
        root_next[j] = {root_in[j][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_next[j]  = rem_sh[j];
        root_next[j] = {root_in[j][ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ISQRT_LAT; j++) begin
        rad_q[j]  <= rad_next[j];
        rem_q[j]  <= rem_next[j];
        root_q[j] <= root_next[j];
      end
    end
  end

  assign root = root_q[ISQRT_LAT-1];

endmodule

/* hw/rtl/qbv_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on qbv_pkg; needs num < den * 2^DIV_LAT
module qbv_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [qbv_pkg::RAD_BITS-1:0]   num,
  input  logic [qbv_pkg::ROOT_BITS-1:0]  den,
  output logic [qbv_pkg::ROOT_BITS-1:0]  quo
);
  import qbv_pkg::*;

  logic [RAD_BITS-1:0]  rem_in   [DIV_LAT];
  logic [ROOT_BITS-1:0] den_in   [DIV_LAT];
  logic [ROOT_BITS-1:0] quo_in   [DIV_LAT];
  logic [RAD_BITS-1:0]  sub      [DIV_LAT];
  logic [RAD_BITS-1:0]  rem_next [DIV_LAT];
  logic [ROOT_BITS-1:0] quo_next [DIV_LAT];
  logic [RAD_BITS-1:0]  rem_q    [DIV_LAT];
  logic [ROOT_BITS-1:0] den_q    [DIV_LAT];
  logic [ROOT_BITS-1:0] quo_q    [DIV_LAT];

  always_comb begin
    rem_in[0] = num;
    den_in[0] = den;
    quo_in[0] = '0;
    for (int j = 1; j < DIV_LAT; j++) begin
      rem_in[j] = rem_q[j-1];
      den_in[j] = den_q[j-1];
      quo_in[j] = quo_q[j-1];
    end
    for (int j = 0; j < DIV_LAT; j++) begin
      sub[j] = RAD_BITS'(den_in[j]) << (DIV_LAT - 1 - j);
      if (rem_in[j] >= sub[j]) begin
        rem_next[j] = rem_in[j] - sub[j];
        quo_next[j] = {quo_in[j][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_next[j] = rem_in[j];
        quo_next[j] = {quo_in[j][ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_LAT; j++) begin
        rem_q[j] <= rem_next[j];
        den_q[j] <= den_in[j];
        quo_q[j] <= quo_next[j];
      end
    end
  end

  assign quo = quo_q[DIV_LAT-1];

endmodule

/* hw/rtl/qbv_norm.sv */
// pipelined vector normalizer: prescale, sum of squares, root, three divides
// depends on qbv_pkg, qbv_isqrt, qbv_div
module qbv_norm (
  input  logic            clk,
  input  logic            en,
  input  qbv_pkg::vec3_t  vec,
  output qbv_pkg::unit_t  unit
);
  import qbv_pkg::*;

  localparam int MW     = WORK_FRAC + 1;
  localparam int SW     = $clog2(MW);
  localparam int LINE_A = ISQRT_LAT + 2;

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
  } side_t;

  logic [2:0][UW-1:0]       comp;
  logic [2:0][MW-1:0]       mag0;
  logic [MW-1:0]            mx;
  logic [2:0][MW-1:0]       mag1;
  logic [2:0]               neg1;
  logic [MW-1:0]            mx1;
  logic [SW-1:0]            sh;
  side_t                    s2;
  logic [2:0][2*MW-1:0]     sq3;
  logic [RAD_BITS-1:0]      sum4;
  logic [ROOT_BITS-1:0]     root;
  side_t                    line_a [LINE_A];
  logic [2:0][RAD_BITS-1:0] num5;
  logic [ROOT_BITS-1:0]     den5;
  logic [3:0]               flag5;
  logic [3:0]               flag_b [DIV_LAT];
  logic [2:0][ROOT_BITS-1:0] quo;

  // magnitudes and their maximum
  always_comb begin
    comp = {vec.z, vec.y, vec.x};
    mx   = '0;
    for (int i = 0; i < 3; i++) begin
      mag0[i] = comp[i][UW-1] ? MW'(-comp[i]) : MW'(comp[i]);
      if (mag0[i] > mx) mx = mag0[i];
    end
  end

  // shift that brings the largest magnitude to at least 2^29
  always_comb begin
    sh = '0;
    for (int b = 0; b < WORK_FRAC - 1; b++) begin
      if (mx1[b]) sh = SW'(WORK_FRAC - 1 - b);
    end
    if (|mx1[MW-1:WORK_FRAC-1]) sh = '0;
  end

  qbv_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum4),
    .root (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    qbv_div u_div (
      .clk (clk),
      .en  (en),
      .num (num5[i]),
      .den (den5),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag0;
      mx1  <= mx;
      for (int i = 0; i < 3; i++) begin
        neg1[i]    <= comp[i][UW-1];
        s2.mag[i]  <= mag1[i] << sh;
        sq3[i]     <= s2.mag[i] * s2.mag[i];
        num5[i]    <= (RAD_BITS'(line_a[LINE_A-1].mag[i]) << WORK_FRAC)
                      + RAD_BITS'(root >> 1);
      end
      s2.neg  <= neg1;
      s2.zero <= (mx1 == '0);
      sum4    <= RAD_BITS'(sq3[0]) + RAD_BITS'(sq3[1]) + RAD_BITS'(sq3[2]);
      line_a[0] <= s2;
      for (int k = 1; k < LINE_A; k++) line_a[k] <= line_a[k-1];
      den5  <= root;
      flag5 <= {line_a[LINE_A-1].zero, line_a[LINE_A-1].neg};
      flag_b[0] <= flag5;
      for (int k = 1; k < DIV_LAT; k++) flag_b[k] <= flag_b[k-1];
      unit.ok  <= !flag_b[DIV_LAT-1][3];
      unit.u.x <= flag_b[DIV_LAT-1][0] ? -$signed(UW'(quo[0])) : $signed(UW'(quo[0]));
      unit.u.y <= flag_b[DIV_LAT-1][1] ? -$signed(UW'(quo[1])) : $signed(UW'(quo[1]));
      unit.u.z <= flag_b[DIV_LAT-1][2] ? -$signed(UW'(quo[2])) : $signed(UW'(quo[2]));
    end
  end

endmodule

/* bench/testbench.sv */
// testbench for quaternion_between_vectors_core: directed table, then random vector pairs
// depends on qbv_pkg and the core RTL; predicts each result with an exact integer model unless the row types it
`timescale 1ns / 100ps

module testbench;
  import qbv_pkg::*;

  typedef struct {
    logic signed [OUT_BITS-1:0] w, x, y, z;
    logic opp, degen;
  } quat_t;

  typedef struct {
    logic signed [COMP_BITS-1:0] sx, sy, sz, dx, dy, dz;
    bit known;  // expected result typed into the table
    quat_t q;
  } vec_pair_t;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic result_stall = 0;
  logic signed [COMP_BITS-1:0] start_x = 0, start_y = 0, start_z = 0;
  logic signed [COMP_BITS-1:0] dest_x = 0, dest_y = 0, dest_z = 0;
  logic item_stall, result_valid, opposite_case, degenerate;
  logic signed [OUT_BITS-1:0] quat_w, quat_x, quat_y, quat_z;

  // expected quaternions, oldest first
  quat_t pending_quats[$];
  // every sent pair, directed or random, taken in send order
  vec_pair_t sent_pairs[$];
  int mismatch_count = 0;
  int pairs_sent = 0;
  int idle_cycles = 0;

  quaternion_between_vectors_core DUT (.*);

  // 4 ns clock
  always #2 clk = ~clk;

  // round to nearest, ties away from zero
  function automatic longint shift_round(longint v, int k);
    longint unsigned m;
    m = ((v < 0 ? -v : v) + (64'd1 << (k - 1))) >> k;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_round(longint n, longint unsigned d);
    longint unsigned m;
    if (d == 0) return 0;
    m = (longint'(n < 0 ? -n : n) + d / 2) / d;
    return n < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit vector in Q1.30, zero flag when the vector has no length
  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, total, nrm;
    mx = 0;
    total = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return 0;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) total += m[i] * m[i];
    nrm = int_sqrt(total);
    for (int i = 0; i < 3; i++)
      u[i] = div_round(v[i] < 0 ? -longint'(m[i] << 30) : longint'(m[i] << 30), nrm);
    return 1;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] to_q14(longint q30);
    longint r;
    r = shift_round(q30, WORK_FRAC - FRAC_BITS);
    if (r > (1 << FRAC_BITS)) r = 1 << FRAC_BITS;
    if (r < -(1 << FRAC_BITS)) r = -(1 << FRAC_BITS);
    return r[OUT_BITS-1:0];
  endfunction

  function automatic quat_t rotation_between(vec_pair_t p);
    longint a[3], b[3], u[3], v[3], ax[3], an[3], cr[3], q[4];
    longint c30;
    longint unsigned lsq, s30;
    bit ok_a, ok_b;
    quat_t r;
    a = '{p.sx, p.sy, p.sz};
    b = '{p.dx, p.dy, p.dz};
    q = '{0, 0, 0, 0};
    r.opp = 0;
    r.degen = 0;
    ok_a = unit_vec(a, u);
    ok_b = unit_vec(b, v);
    if (!ok_a || !ok_b) begin
      r.degen = 1;
    end else begin
      c30 = shift_round(u[0] * v[0] + u[1] * v[1] + u[2] * v[2], WORK_FRAC);
      if (c30 < -(64'sd1 << 30) + 1073742) begin
        // half turn about an axis perpendicular to start
        r.opp = 1;
        lsq = u[0] * u[0] + u[1] * u[1];
        if (lsq < SMALL_AXIS_SQ) ax = '{0, -u[2], u[1]};
        else ax = '{-u[1], u[0], 0};
        void'(unit_vec(ax, an));
        q = '{0, an[0], an[1], an[2]};
      end else begin
        cr[0] = shift_round(u[1] * v[2] - u[2] * v[1], WORK_FRAC);
        cr[1] = shift_round(u[2] * v[0] - u[0] * v[2], WORK_FRAC);
        cr[2] = shift_round(u[0] * v[1] - u[1] * v[0], WORK_FRAC);
        s30 = int_sqrt((2 * ((64'sd1 << 30) + c30)) << 30);
        q[0] = div_round(s30, 2);
        for (int i = 0; i < 3; i++) q[i + 1] = div_round(cr[i] << 30, s30);
      end
    end
    r.w = r.degen ? '0 : to_q14(q[0]);
    r.x = r.degen ? '0 : to_q14(q[1]);
    r.y = r.degen ? '0 : to_q14(q[2]);
    r.z = r.degen ? '0 : to_q14(q[3]);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic vec_pair_t row(int sx, int sy, int sz, int dx, int dy, int dz,
                                    bit known = 0, int w = 0, int x = 0, int y = 0,
                                    int z = 0, bit opp = 0, bit degen = 0);
    vec_pair_t p;
    p.sx = COMP_BITS'(sx); p.sy = COMP_BITS'(sy); p.sz = COMP_BITS'(sz);
    p.dx = COMP_BITS'(dx); p.dy = COMP_BITS'(dy); p.dz = COMP_BITS'(dz);
    p.known = known;
    p.q.w = OUT_BITS'(w); p.q.x = OUT_BITS'(x); p.q.y = OUT_BITS'(y); p.q.z = OUT_BITS'(z);
    p.q.opp = opp; p.q.degen = degen;
    return p;
  endfunction

  // random pair, mostly full range, some tiny, near opposite, zero or parallel
  function automatic vec_pair_t random_pair();
    vec_pair_t p;
    int kind;
    kind = $urandom_range(0, 99);
    p = row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (kind < 10) begin
      p = row($signed($urandom_range(0, 6)) - 3, $signed($urandom_range(0, 6)) - 3,
              $signed($urandom_range(0, 6)) - 3, $signed($urandom_range(0, 6)) - 3,
              $signed($urandom_range(0, 6)) - 3, $signed($urandom_range(0, 6)) - 3);
    end else if (kind < 25) begin
      // destination almost opposite to start
      p.sx = COMP_BITS'($signed($urandom_range(0, 20000)) - 10000);
      p.sy = COMP_BITS'($signed($urandom_range(0, 20000)) - 10000);
      p.sz = COMP_BITS'($signed($urandom_range(0, 20000)) - 10000);
      if ($urandom_range(0, 3) == 0) begin
        p.sx = COMP_BITS'($signed($urandom_range(0, 8)) - 4);
        p.sy = COMP_BITS'($signed($urandom_range(0, 8)) - 4);
      end
      p.dx = COMP_BITS'(-p.sx + $signed($urandom_range(0, 40)) - 20);
      p.dy = COMP_BITS'(-p.sy + $signed($urandom_range(0, 40)) - 20);
      p.dz = COMP_BITS'(-p.sz + $signed($urandom_range(0, 40)) - 20);
    end else if (kind < 30) begin
      if ($urandom_range(0, 1)) {p.sx, p.sy, p.sz} = '0;
      else {p.dx, p.dy, p.dz} = '0;
    end else if (kind < 35) begin
      p.dx = p.sx >>> 2;
      p.dy = p.sy >>> 2;
      p.dz = p.sz >>> 2;
    end
    return p;
  endfunction

  // one check process: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    quat_t want;
    vec_pair_t p;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        p = sent_pairs.pop_front();
        pending_quats.insert(pending_quats.size(), p.known ? p.q : rotation_between(p));
      end
      if (result_valid && !result_stall) begin
        if (pending_quats.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = pending_quats.pop_front();
          if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
          if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
          if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
          if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
          if (opposite_case !== want.opp)
            report_mismatch("opposite_case", opposite_case, want.opp);
          if (degenerate !== want.degen) report_mismatch("degenerate", degenerate, want.degen);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, a calm stretch, and one long hold-off to fill the pipeline
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result_stall = 1;
        hold--;
      end else if (!held && pairs_sent >= 900) begin
        held = 1;
        hold = 400;
        result_stall = 1;
      end else if (pairs_sent > 400 && pairs_sent < 700) begin
        result_stall = 0;
      end else begin
        result_stall = $urandom_range(0, 99) < 25;
      end
    end
  end

  initial begin
    vec_pair_t directed[$];
    vec_pair_t p;
    int settle;
    directed = '{
      row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1),
      row(0, 0, 0, 5, -3, 2, 1, 0, 0, 0, 0, 0, 1),
      row(-32768, 7, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1),
      row(1, 0, 0, 1, 0, 0, 1, 16384, 0, 0, 0, 0, 0),
      row(32767, 32767, 32767, 32767, 32767, 32767),
      // straight opposite along x and along z, both fallback axes
      row(1, 0, 0, -1, 0, 0, 1, 0, 0, 16384, 0, 1, 0),
      row(0, 0, 1, 0, 0, -1, 1, 0, 0, -16384, 0, 1, 0),
      row(-32768, -32768, -32768, 32767, 32767, 32767),
      row(32767, 0, 0, 0, 32767, 0),
      row(-32768, 0, 0, 0, 0, -32768),
      row(-32768, -32768, -32768, -32768, -32768, -32768),
      row(1, 1, 1, -1, -1, -1),
      row(1000, 2000, 3000, -1001, -2000, -3000),
      row(1, 0, 1000, -1, 0, -1000),
      row(16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h1234, 16'hFEDC),
      row(-1, -1, -1, 1, -1, 1),
      row(0, 32767, 0, 0, -32768, 0)
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    for (int n = 0; n < directed.size() + 1450; n++) begin
      p = n < directed.size() ? directed[n] : random_pair();
      // sender gaps, none in the calm stretch
      while (!(n > 400 && n < 700) && $urandom_range(0, 99) < 25) begin
        item_valid = 0;
        @(negedge clk);
      end
      {start_x, start_y, start_z, dest_x, dest_y, dest_z} =
        {p.sx, p.sy, p.sz, p.dx, p.dy, p.dz};
      sent_pairs.insert(sent_pairs.size(), p);
      item_valid = 1;
      @(posedge clk);
      while (item_stall) @(posedge clk);
      pairs_sent++;
      @(negedge clk);
    end
    item_valid = 0;
    while (pending_quats.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
